// File: hw/rtl/code_block_cache_allocator_unit_macros.svh
// Assertion macros shared by the code block cache allocator RTL.
`ifndef CODE_BLOCK_CACHE_ALLOCATOR_UNIT_MACROS_SVH
`define CODE_BLOCK_CACHE_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CBCA_ASSERT_IMPLY(label, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (lhs) |-> (rhs)) \
		else $error("cbca: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define CBCA_ASSERT_NEXT(label, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (lhs) |=> (rhs)) \
		else $error("cbca: next-cycle check failed");

`endif

// File: hw/rtl/cbca_pkg.sv
// Types, constants and codes shared by the code block cache allocator.
`default_nettype none
package cbca_pkg;

	localparam int DEF_TABLE_ENTRIES = 64;
	localparam int DEF_BLOCK_BYTES   = 64;

	// Width of a rounded size and of the capacity registers.
	localparam int ALIGN_W = 25;
	localparam int CAP_W   = 25;
	localparam int PADDR_W = 4;

	localparam logic [31:0]      RST_ALLOC_BASE = 32'h0001_0000;
	localparam logic [CAP_W-1:0] RST_ALLOC_CAP  = 25'h003_0000;
	localparam logic [31:0]      RST_SRC_BASE   = 32'h8000_0000;
	localparam logic [31:0]      RST_SRC_SIZE   = 32'h1000_0000;

	localparam logic [1:0] REG_ALLOC_BASE = 2'd0;
	localparam logic [1:0] REG_ALLOC_CAP  = 2'd1;
	localparam logic [1:0] REG_SRC_BASE   = 2'd2;
	localparam logic [1:0] REG_SRC_SIZE   = 2'd3;

	localparam logic [2:0] STATUS_HIT       = 3'd0;
	localparam logic [2:0] STATUS_LOADED    = 3'd1;
	localparam logic [2:0] STATUS_INVALID   = 3'd2;
	localparam logic [2:0] STATUS_TOO_LARGE = 3'd3;
	localparam logic [2:0] STATUS_FLUSHED   = 3'd4;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

	typedef struct packed {
		logic        mode;
		logic [31:0] source_addr;
		logic [23:0] byte_size;
	} cbca_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] target_addr;
		logic        evicted;
		logic        table_full;
		logic [31:0] hit_total;
		logic [31:0] miss_total;
		logic [31:0] load_total;
		logic [31:0] evict_total;
		logic [31:0] bytes_total;
	} cbca_rsp_t;

	// Search token handed from cell to cell along the mapping table.
	typedef struct packed {
		logic        valid;
		logic        found;
		logic [31:0] target;
	} cbca_token_t;

	// Broadcast write of a new mapping; the cell at the write index takes it.
	typedef struct packed {
		logic        en;
		logic [31:0] source;
		logic [31:0] target;
	} cbca_wr_t;

endpackage
`default_nettype wire

// File: hw/rtl/cbca_cell.sv
// One mapping table cell: holds an entry and passes the search token on.
`default_nettype none
module cbca_cell import cbca_pkg::*; #(
	parameter int INDEX = 0,
	parameter int CW    = 7,
	parameter int IW    = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CW-1:0]     count,
	input  logic [31:0]       search_addr,
	input  cbca_token_t       tok_in,
	output cbca_token_t       tok_out,
	input  cbca_wr_t          wr,
	input  logic [IW-1:0]     wr_idx
);

	localparam logic [CW-1:0] MY_COUNT = CW'(INDEX);
	localparam logic [IW-1:0] MY_IDX   = IW'(INDEX);

	logic [31:0] source_q;
	logic [31:0] target_q;
	cbca_token_t tok_q;
	logic        match;

	// The entry is live only while it lies below the fill count.
	assign match = tok_in.valid && !tok_in.found && (MY_COUNT < count)
		&& (source_q == search_addr);

	always_ff @(posedge clk) begin
		if (wr.en && (wr_idx == MY_IDX)) begin
			source_q <= wr.source;
			target_q <= wr.target;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.valid  <= tok_in.valid;
			tok_q.found  <= tok_in.found | match;
			tok_q.target <= match ? target_q : tok_in.target;
		end
	end

	assign tok_out = tok_q;

endmodule
`default_nettype wire

// File: hw/rtl/cbca_align.sv
// Rounds a byte size up to the granule with a registered reciprocal multiply.
`default_nettype none
module cbca_align import cbca_pkg::*; #(
	parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [23:0]        size,
	output logic               done,
	output logic [ALIGN_W-1:0] aligned
);

	// With a shift of ALIGN_W plus the granule's log2 and the reciprocal rounded up, the
	// product gives the exact quotient for every value below 2**ALIGN_W.
	localparam int GL = $clog2(BLOCK_BYTES);
	localparam int SH = ALIGN_W + GL;
	localparam int MW = ALIGN_W + 1;
	localparam longint unsigned RECIP_L =
		((64'd1 << SH) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);
	localparam logic [MW-1:0]      RECIP   = MW'(RECIP_L);
	localparam logic [ALIGN_W-1:0] GRAN    = ALIGN_W'(BLOCK_BYTES);
	localparam logic [ALIGN_W-1:0] GRAN_M1 = ALIGN_W'(BLOCK_BYTES - 1);

	logic                  st_s1;
	logic                  st_s2;
	logic                  done_q;
	logic [ALIGN_W-1:0]    num_s1;
	logic [ALIGN_W-1:0]    quot_s2;
	logic [ALIGN_W-1:0]    aligned_q;
	logic [ALIGN_W+MW-1:0] prod;

	assign prod = {{MW{1'b0}}, num_s1} * {{ALIGN_W{1'b0}}, RECIP};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s1  <= 1'b0;
			st_s2  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			st_s1 <= start;
			st_s2 <= st_s1;
			if (start) begin
				done_q <= 1'b0;
			end else if (st_s2) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_s1 <= ALIGN_W'(size) + GRAN_M1;
		end
		if (st_s1) begin
			quot_s2 <= ALIGN_W'(prod >> SH);
		end
		if (st_s2) begin
			aligned_q <= ALIGN_W'(quot_s2 * GRAN);
		end
	end

	assign done    = done_q;
	assign aligned = aligned_q;

endmodule
`default_nettype wire

// File: hw/rtl/code_block_cache_allocator_unit.sv
// A load searches the table, then passes through check, commit and delivery before rsp_valid
// rises from the output register; the size rounding runs beside the search and never adds.
// A flush, a zero size or a zero source address skips the search and the check and goes
// straight to commit. One request is in work at a time; the next can be taken in the cycle
// in which rsp_valid rises at the soonest.
// Reset clears counters and fill count and loads register defaults; entries have no reset.
`default_nettype none
`include "code_block_cache_allocator_unit_macros.svh"
module code_block_cache_allocator_unit import cbca_pkg::*; #(
	parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
	parameter int BLOCK_BYTES   = DEF_BLOCK_BYTES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  cbca_req_t          req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output cbca_rsp_t          rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

	typedef enum logic [4:0] {
		S_IDLE    = 5'b00001,
		S_SEARCH  = 5'b00010,
		S_CHECK   = 5'b00100,
		S_COMMIT  = 5'b01000,
		S_DELIVER = 5'b10000
	} state_t;

	state_t state_q, state_d;

	// Configuration registers.
	logic [31:0]      alloc_base_q;
	logic [CAP_W-1:0] alloc_cap_q;
	logic [31:0]      src_base_q;
	logic [31:0]      src_size_q;

	// Allocator state and counters.
	logic [CW-1:0]    count_q;
	logic [31:0]      next_free_q;
	logic [CAP_W-1:0] space_left_q;
	logic [31:0]      hits_q, misses_q, loads_q, evictions_q, bytes_q;

	// Request being served and its intermediate results.
	cbca_req_t        req_q;
	logic             srch_done_q;
	logic             found_q;
	logic [31:0]      hit_target_q;
	logic             in_window_q;
	logic             too_large_q;
	logic             need_flush_q;

	// Result fields that wait for the output register.
	logic [2:0]       res_status_q;
	logic [31:0]      res_target_q;
	logic             res_evicted_q;
	logic             res_full_q;

	logic             rsp_valid_q;
	cbca_rsp_t        rsp_q;

	logic             accept;
	logic             cfg_write;
	logic             short_req;
	logic             div_done;
	logic [ALIGN_W-1:0] aligned;
	logic [32:0]      window_end;

	cbca_token_t      tok [TABLE_ENTRIES+1];
	cbca_token_t      tok0_q;
	cbca_wr_t         wr;
	logic [IW-1:0]    wr_idx;

	// Commit-cycle values.
	logic             load_ok;
	logic [31:0]      base_free;
	logic [CAP_W-1:0] base_space;
	logic [CW-1:0]    eff_count;
	logic             room;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign short_req = (req.mode == MODE_FLUSH) || (req.source_addr == 32'd0)
		|| (req.byte_size == 24'd0);

	// ---------------------------------------------------------------
	// Configuration port. Writes land on the access phase; reads are
	// served from the register file with no wait states.
	// ---------------------------------------------------------------
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_base_q <= RST_ALLOC_BASE;
			alloc_cap_q  <= RST_ALLOC_CAP;
			src_base_q   <= RST_SRC_BASE;
			src_size_q   <= RST_SRC_SIZE;
		end else if (cfg_write) begin
			case (paddr[3:2])
				REG_ALLOC_BASE: alloc_base_q <= pwdata;
				REG_ALLOC_CAP:  alloc_cap_q  <= pwdata[CAP_W-1:0];
				REG_SRC_BASE:   src_base_q   <= pwdata;
				REG_SRC_SIZE:   src_size_q   <= pwdata;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_ALLOC_BASE: prdata = alloc_base_q;
			REG_ALLOC_CAP:  prdata = {{(32 - CAP_W){1'b0}}, alloc_cap_q};
			REG_SRC_BASE:   prdata = src_base_q;
			REG_SRC_SIZE:   prdata = src_size_q;
			default:        prdata = 32'd0;
		endcase
	end

	// ---------------------------------------------------------------
	// Mapping table: a row of cells. A search token enters cell 0 the
	// cycle after acceptance, once the request address is registered,
	// and moves one cell per cycle. The first live match wins.
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok0_q <= '0;
		end else begin
			tok0_q.valid  <= accept && !short_req;
			tok0_q.found  <= 1'b0;
			tok0_q.target <= 32'd0;
		end
	end

	assign tok[0] = tok0_q;

	for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
		cbca_cell #(
			.INDEX (g),
			.CW    (CW),
			.IW    (IW)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.count       (count_q),
			.search_addr (req_q.source_addr),
			.tok_in      (tok[g]),
			.tok_out     (tok[g+1]),
			.wr          (wr),
			.wr_idx      (wr_idx)
		);
	end

	// The size is rounded in parallel with the search.
	cbca_align #(
		.BLOCK_BYTES (BLOCK_BYTES)
	) u_align (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept && !short_req),
		.size    (req.byte_size),
		.done    (div_done),
		.aligned (aligned)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (tok[TABLE_ENTRIES].valid) begin
			found_q      <= tok[TABLE_ENTRIES].found;
			hit_target_q <= tok[TABLE_ENTRIES].target;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srch_done_q <= 1'b0;
		end else if (accept) begin
			srch_done_q <= 1'b0;
		end else if (tok[TABLE_ENTRIES].valid) begin
			srch_done_q <= 1'b1;
		end
	end

	// ---------------------------------------------------------------
	// Window and space checks on the rounded size. The window end is
	// formed one bit wider so that it never wraps.
	// ---------------------------------------------------------------
	assign window_end = {1'b0, src_base_q} + {1'b0, src_size_q};

	always_ff @(posedge clk) begin
		if (state_q == S_CHECK) begin
			in_window_q  <= (req_q.source_addr >= src_base_q)
				&& ({1'b0, req_q.source_addr} < window_end);
			too_large_q  <= aligned > alloc_cap_q;
			need_flush_q <= aligned > space_left_q;
		end
	end

	// ---------------------------------------------------------------
	// Commit. A load that runs out of space flushes first and then
	// allocates from the refreshed base.
	// ---------------------------------------------------------------
	assign load_ok    = (req_q.mode == MODE_LOAD) && (req_q.source_addr != 32'd0)
		&& (req_q.byte_size != 24'd0) && !found_q && in_window_q && !too_large_q;
	assign base_free  = need_flush_q ? alloc_base_q : next_free_q;
	assign base_space = need_flush_q ? alloc_cap_q : space_left_q;
	assign eff_count  = need_flush_q ? '0 : count_q;
	assign room       = eff_count < FULL_COUNT;

	assign wr.en     = (state_q == S_COMMIT) && load_ok && room;
	assign wr.source = req_q.source_addr;
	assign wr.target = base_free;
	assign wr_idx    = eff_count[IW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			next_free_q  <= RST_ALLOC_BASE;
			space_left_q <= RST_ALLOC_CAP;
			hits_q       <= '0;
			misses_q     <= '0;
			loads_q      <= '0;
			evictions_q  <= '0;
			bytes_q      <= '0;
		end else if (state_q == S_COMMIT) begin
			if (req_q.mode == MODE_FLUSH) begin
				count_q      <= '0;
				next_free_q  <= alloc_base_q;
				space_left_q <= alloc_cap_q;
				evictions_q  <= evictions_q + 32'd1;
			end else if ((req_q.source_addr != 32'd0) && (req_q.byte_size != 24'd0)) begin
				if (found_q) begin
					hits_q <= hits_q + 32'd1;
				end else if (in_window_q) begin
					misses_q <= misses_q + 32'd1;
					if (!too_large_q) begin
						if (need_flush_q) begin
							evictions_q <= evictions_q + 32'd1;
						end
						next_free_q  <= base_free + {{(32 - ALIGN_W){1'b0}}, aligned};
						space_left_q <= base_space - CAP_W'(aligned);
						count_q      <= room ? eff_count + 1'b1 : eff_count;
						loads_q      <= loads_q + 32'd1;
						bytes_q      <= bytes_q + {{(32 - ALIGN_W){1'b0}}, aligned};
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_COMMIT) begin
			res_status_q  <= STATUS_INVALID;
			res_target_q  <= 32'd0;
			res_evicted_q <= 1'b0;
			res_full_q    <= 1'b0;
			if (req_q.mode == MODE_FLUSH) begin
				res_status_q  <= STATUS_FLUSHED;
				res_evicted_q <= 1'b1;
			end else if ((req_q.source_addr != 32'd0) && (req_q.byte_size != 24'd0)) begin
				if (found_q) begin
					res_status_q <= STATUS_HIT;
					res_target_q <= hit_target_q;
				end else if (in_window_q) begin
					if (too_large_q) begin
						res_status_q <= STATUS_TOO_LARGE;
					end else begin
						res_status_q  <= STATUS_LOADED;
						res_target_q  <= base_free;
						res_evicted_q <= need_flush_q;
						res_full_q    <= !room;
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Sequencer.
	// ---------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = short_req ? S_COMMIT : S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (srch_done_q && div_done) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				state_d = S_DELIVER;
			end
			S_DELIVER: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------------------------------------------------------
	// Output register. The counters are sampled here: they cannot move
	// again before the next request reaches its commit; that request's
	// delivery in turn waits for this word to leave.
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == S_DELIVER) && (!rsp_valid_q || rsp_ready)) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DELIVER) && (!rsp_valid_q || rsp_ready)) begin
			rsp_q.status      <= res_status_q;
			rsp_q.target_addr <= res_target_q;
			rsp_q.evicted     <= res_evicted_q;
			rsp_q.table_full  <= res_full_q;
			rsp_q.hit_total   <= hits_q;
			rsp_q.miss_total  <= misses_q;
			rsp_q.load_total  <= loads_q;
			rsp_q.evict_total <= evictions_q;
			rsp_q.bytes_total <= bytes_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// ---------------------------------------------------------------
	// Assertions.
	// ---------------------------------------------------------------
	`CBCA_ASSERT_IMPLY(a_count_bound, 1'b1, count_q <= FULL_COUNT)
	`CBCA_ASSERT_IMPLY(a_write_in_commit, wr.en, state_q == S_COMMIT)
	`CBCA_ASSERT_IMPLY(a_align_ready, state_q == S_CHECK, div_done && srch_done_q)
	`CBCA_ASSERT_NEXT(a_deliver, (state_q == S_DELIVER) && (!rsp_valid_q || rsp_ready),
		rsp_valid_q && (state_q == S_IDLE))

endmodule
`default_nettype wire
